// ----- sv/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg: shared types and helpers for the source text tokenizer
// Word formats, scan modes, character constants and class tests.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

	localparam int MaxRes = 4;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [2:0] token_kind;
		logic       has_char;
		logic [7:0] value_char;
		logic       token_end;
		logic [1:0] error_code;
		logic       run_last;
	} out_word_t;

	typedef struct packed {
		out_word_t [MaxRes-1:0] r;
		logic [2:0]             n;
	} res_list_t;

	localparam logic [2:0] K_IDENT  = 3'd0;
	localparam logic [2:0] K_INT    = 3'd1;
	localparam logic [2:0] K_OPER   = 3'd2;
	localparam logic [2:0] K_STRING = 3'd3;
	localparam logic [2:0] K_SPACE  = 3'd4;
	localparam logic [2:0] K_PUNCT  = 3'd5;

	localparam logic [1:0] E_NONE    = 2'd0;
	localparam logic [1:0] E_UNTERM  = 2'd1;
	localparam logic [1:0] E_ESCAPE  = 2'd2;
	localparam logic [1:0] E_UNKNOWN = 2'd3;

	typedef enum logic [8:0] {
		M_IDLE    = 9'b000000001,
		M_IDENT   = 9'b000000010,
		M_INT     = 9'b000000100,
		M_OPER    = 9'b000001000,
		M_SLASH   = 9'b000010000,
		M_STRING  = 9'b000100000,
		M_ESCAPE  = 9'b001000000,
		M_SPACE   = 9'b010000000,
		M_COMMENT = 9'b100000000
	} scan_mode_t;

	localparam logic [7:0] C_NUL   = 8'd0;
	localparam logic [7:0] C_TAB   = 8'd9;
	localparam logic [7:0] C_NL    = 8'd10;
	localparam logic [7:0] C_SP    = 8'd32;
	localparam logic [7:0] C_QUOTE = 8'd34;
	localparam logic [7:0] C_SLASH = 8'd47;
	localparam logic [7:0] C_BSL   = 8'd92;
	localparam logic [7:0] C_UNDER = 8'd95;
	localparam logic [7:0] C_LOW_N = 8'd110;
	localparam logic [7:0] C_LOW_T = 8'd116;

	function automatic logic is_letter(logic [7:0] c);
		return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	function automatic logic is_space(logic [7:0] c, logic tab_en);
		return c == C_SP || c == C_NL || (c == C_TAB && tab_en);
	endfunction

	function automatic logic is_punct(logic [7:0] c);
		return c == 8'd40 || c == 8'd41 || c == 8'd59 || c == 8'd44;
	endfunction

	// + - * / < > & . @ : = ~ | $ ! # % ^ _ [ ] { } " ` ?
	function automatic logic is_opsym(logic [7:0] c);
		logic r;
		case (c) inside
			8'd43, 8'd45, 8'd42, 8'd47, 8'd60, 8'd62, 8'd38, 8'd46, 8'd64,
			8'd58, 8'd61, 8'd126, 8'd124, 8'd36, 8'd33, 8'd35, 8'd37, 8'd94,
			8'd95, 8'd91, 8'd93, 8'd123, 8'd125, 8'd34, 8'd96, 8'd63: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic out_word_t mk(logic [2:0] kind, logic has, logic [7:0] val,
			logic fin, logic [1:0] err);
		out_word_t w;
		w.token_kind = kind;
		w.has_char   = has;
		w.value_char = val;
		w.token_end  = fin;
		w.error_code = err;
		w.run_last   = 1'b0;
		return w;
	endfunction

	// append one result; a full list drops it
	function automatic res_list_t push(res_list_t l, out_word_t w);
		res_list_t o;
		o = l;
		if (l.n != 3'(MaxRes)) begin
			o.r[l.n[1:0]] = w;
			o.n = l.n + 3'd1;
		end
		return o;
	endfunction

endpackage

`default_nettype wire

// ----- sv/source_text_tokenizer.sv -----
// ----------------------------------------------------------------------------
// source_text_tokenizer: byte-stream lexer
// Groups source bytes into identifier, integer, operator, string, space or
// comment, and punctuation tokens; flags bad bytes, escapes, open strings.
// ----------------------------------------------------------------------------
//
//  port group   dir   content
//  in_*         in    one source byte and its end-of-text flag per word
//  out_*        out   one token character, end marker or error per word
//  cfg_*        in    tab_as_space register write (always ready)
//
//  A byte is decoded in the cycle it is accepted; its 0 to 4 results go into
//  a 4-deep result register and leave one per cycle. The source side takes a
//  new byte whenever that register is empty or giving up its last result.
//  Output stalls hold the result register and back up into in_ready. Reset
//  clears the scan mode, empties the result register and sets tab_as_space.
`default_nettype none

module source_text_tokenizer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire stt_pkg::in_word_t  in_word,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output stt_pkg::out_word_t      out_word,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_data
);
	import stt_pkg::*;

	scan_mode_t             mode_q, mode_d, mode_a;
	logic                   tab_q;
	out_word_t [MaxRes-1:0] res_q;
	out_word_t [MaxRes-1:0] load_w;
	logic [2:0]             cnt_q;
	res_list_t              lst, lst_a;
	logic [7:0]             c;
	logic                   eot;
	logic                   do_start;
	logic                   in_acc, pop;
	logic [1:0]             last_idx;

	assign c      = in_word.ch;
	assign eot    = in_word.end_of_text;
	assign in_acc = in_valid && in_ready;
	assign pop    = out_valid && out_ready;

	assign cfg_ready = 1'b1;
	assign out_valid = cnt_q != 3'd0;
	assign out_word  = res_q[0];
	// room once the last buffered result leaves this cycle
	assign in_ready  = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_ready);

	// ---- decode: continue the open token, or close it and restart ----
	always_comb begin
		lst      = '0;
		mode_a   = mode_q;
		do_start = 1'b0;
		unique case (mode_q)
			M_IDENT: begin
				if (is_letter(c) || is_digit(c) || c == C_UNDER) begin
					lst = push(lst, mk(K_IDENT, 1'b1, c, 1'b0, E_NONE));
				end else begin
					lst = push(lst, mk(K_IDENT, 1'b0, 8'd0, 1'b1, E_NONE));
					do_start = 1'b1;
				end
			end
			M_INT: begin
				if (is_digit(c)) begin
					lst = push(lst, mk(K_INT, 1'b1, c, 1'b0, E_NONE));
				end else begin
					lst = push(lst, mk(K_INT, 1'b0, 8'd0, 1'b1, E_NONE));
					do_start = 1'b1;
				end
			end
			M_OPER: begin
				if (is_opsym(c)) begin
					lst = push(lst, mk(K_OPER, 1'b1, c, 1'b0, E_NONE));
				end else begin
					lst = push(lst, mk(K_OPER, 1'b0, 8'd0, 1'b1, E_NONE));
					do_start = 1'b1;
				end
			end
			M_SLASH: begin
				// held slash: second slash opens a comment
				if (c == C_SLASH) begin
					mode_a = M_COMMENT;
				end else begin
					lst = push(lst, mk(K_OPER, 1'b1, C_SLASH, 1'b0, E_NONE));
					if (is_opsym(c)) begin
						lst    = push(lst, mk(K_OPER, 1'b1, c, 1'b0, E_NONE));
						mode_a = M_OPER;
					end else begin
						lst = push(lst, mk(K_OPER, 1'b0, 8'd0, 1'b1, E_NONE));
						do_start = 1'b1;
					end
				end
			end
			M_STRING: begin
				if (c == C_QUOTE) begin
					lst    = push(lst, mk(K_STRING, 1'b0, 8'd0, 1'b1, E_NONE));
					mode_a = M_IDLE;
				end else if (c == C_BSL) begin
					mode_a = M_ESCAPE;
				end else if (c == C_NUL) begin
					lst    = push(lst, mk(K_STRING, 1'b0, 8'd0, 1'b1, E_UNTERM));
					mode_a = M_IDLE;
				end else begin
					lst = push(lst, mk(K_STRING, 1'b1, c, 1'b0, E_NONE));
				end
			end
			M_ESCAPE: begin
				mode_a = M_STRING;
				case (c) inside
					C_LOW_N: lst = push(lst, mk(K_STRING, 1'b1, C_NL, 1'b0, E_NONE));
					C_LOW_T: lst = push(lst, mk(K_STRING, 1'b1, C_TAB, 1'b0, E_NONE));
					C_BSL, C_QUOTE, 8'd40, 8'd41, 8'd59, 8'd44:
						lst = push(lst, mk(K_STRING, 1'b1, c, 1'b0, E_NONE));
					default: begin
						lst = push(lst, mk(K_STRING, 1'b0, c, 1'b1,
							(c == C_NUL) ? E_UNTERM : E_ESCAPE));
						mode_a = M_IDLE;
					end
				endcase
			end
			M_SPACE: begin
				if (!is_space(c, tab_q)) begin
					lst = push(lst, mk(K_SPACE, 1'b0, 8'd0, 1'b1, E_NONE));
					do_start = 1'b1;
				end
			end
			M_COMMENT: begin
				// newline ends the comment and opens a space run
				if (c == C_NL) begin
					lst    = push(lst, mk(K_SPACE, 1'b0, 8'd0, 1'b1, E_NONE));
					mode_a = M_SPACE;
				end else begin
					lst = push(lst, mk(K_SPACE, 1'b1, c, 1'b0, E_NONE));
				end
			end
			default: do_start = 1'b1;
		endcase

		// ---- start a new token with this byte ----
		if (do_start) begin
			if (is_space(c, tab_q)) begin
				mode_a = M_SPACE;
			end else if (c == C_QUOTE) begin
				mode_a = M_STRING;
			end else if (is_letter(c)) begin
				lst    = push(lst, mk(K_IDENT, 1'b1, c, 1'b0, E_NONE));
				mode_a = M_IDENT;
			end else if (is_digit(c)) begin
				lst    = push(lst, mk(K_INT, 1'b1, c, 1'b0, E_NONE));
				mode_a = M_INT;
			end else if (c == C_SLASH) begin
				mode_a = M_SLASH;
			end else if (is_opsym(c)) begin
				lst    = push(lst, mk(K_OPER, 1'b1, c, 1'b0, E_NONE));
				mode_a = M_OPER;
			end else if (is_punct(c)) begin
				lst    = push(lst, mk(K_PUNCT, 1'b1, c, 1'b0, E_NONE));
				lst    = push(lst, mk(K_PUNCT, 1'b0, 8'd0, 1'b1, E_NONE));
				mode_a = M_IDLE;
			end else begin
				// unknown byte: error word, kind identifier, not an end marker
				lst    = push(lst, mk(K_IDENT, 1'b0, c, 1'b0, E_UNKNOWN));
				mode_a = M_IDLE;
			end
		end
	end

	// ---- end of text: flush whatever token is still open ----
	always_comb begin
		lst_a  = lst;
		mode_d = mode_a;
		if (eot) begin
			mode_d = M_IDLE;
			unique case (mode_a) inside
				M_IDENT:  lst_a = push(lst, mk(K_IDENT, 1'b0, 8'd0, 1'b1, E_NONE));
				M_INT:    lst_a = push(lst, mk(K_INT, 1'b0, 8'd0, 1'b1, E_NONE));
				M_OPER:   lst_a = push(lst, mk(K_OPER, 1'b0, 8'd0, 1'b1, E_NONE));
				M_SLASH:  lst_a = push(push(lst, mk(K_OPER, 1'b1, C_SLASH, 1'b0, E_NONE)),
					mk(K_OPER, 1'b0, 8'd0, 1'b1, E_NONE));
				M_STRING, M_ESCAPE:
					lst_a = push(lst, mk(K_STRING, 1'b0, 8'd0, 1'b1, E_UNTERM));
				M_SPACE, M_COMMENT:
					lst_a = push(lst, mk(K_SPACE, 1'b0, 8'd0, 1'b1, E_NONE));
				default: lst_a = lst;
			endcase
		end
	end

	assign last_idx = lst_a.n[1:0] - 2'd1;

	// tag the final result of the byte
	always_comb begin
		load_w = lst_a.r;
		if (lst_a.n != 3'd0) load_w[last_idx].run_last = 1'b1;
	end

	// ---- state and tab register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			tab_q  <= 1'b1;
		end else begin
			if (in_acc) mode_q <= mode_d;
			if (cfg_valid && cfg_ready) tab_q <= cfg_data;
		end
	end

	// ---- result register: load a byte's results, drain from the head ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (in_acc) begin
			cnt_q <= lst_a.n;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < MaxRes; i++) begin
				res_q[i] <= load_w[i];
			end
		end else if (pop) begin
			for (int i = 0; i < MaxRes - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

	// ---- checks ----
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(MaxRes))
		else $error("result count out of range");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.run_last == (cnt_q == 3'd1)))
		else $error("run_last not on the final result of a byte");

	a_mode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(mode_q))
		else $error("scan mode not one-hot");

	a_eot_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_word.end_of_text |=> mode_q == M_IDLE)
		else $error("scan mode not idle after end of text");

endmodule

`default_nettype wire
